/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i with active-low rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define LFGD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// checked at every edge, reset included
`define LFGD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define LFGD_ASSERT(name, prop, msg)
`define LFGD_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

/* sv/lfgd_pkg.sv */
// ----------------------------------------------------------------------------
// lfgd_pkg
// shared types, constants and the gamma table of the led frame renderer
// ----------------------------------------------------------------------------
`default_nettype none

package lfgd_pkg;

  localparam int PIXEL_COUNT  = 3;
  localparam int FITTED_COUNT = 3;
  localparam int LEVEL_COUNT  = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_Q_W   = 8;

  localparam logic [8:0]  DT_MAX      = 9'd500;
  localparam logic [15:0] AVG_RESET   = 16'd256;
  localparam logic [7:0]  FACTOR_MIN  = 8'd20;
  localparam logic [7:0]  FACTOR_MAX  = 8'd255;
  localparam logic [7:0]  FACTOR_SPAN = 8'd235;
  localparam logic [7:0]  DARK_LIMIT  = 8'd12;
  localparam logic [15:0] ROUND_HALF  = 16'd128;
  // ceil(2^32 / 255), exact quotient for every 24-bit dividend
  localparam logic [24:0] RECIP_255   = 25'd16843010;

  localparam logic [7:0]  USER_RESET     = 8'd255;
  localparam logic [15:0] WIN_LOW_RESET  = 16'd0;
  localparam logic [15:0] WIN_HIGH_RESET = 16'd4095;
  localparam logic [8:0]  FRAME_IV_RESET = 9'd16;
  localparam logic [8:0]  DITHER_RESET   = 9'd33;

  typedef enum logic [2:0] {
    REG_USER_BRIGHTNESS = 3'd0,
    REG_WINDOW_LOW      = 3'd1,
    REG_WINDOW_HIGH     = 3'd2,
    REG_FRAME_INTERVAL  = 3'd3,
    REG_DITHER_MAX      = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_INTERVAL,
    FE_AVERAGE,
    FE_RANGE,
    FE_DIVIDE,
    FE_SCALE,
    FE_GAMMA,
    FE_PUSH
  } fe_state_e;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_MUL1,
    BE_MUL2,
    BE_SCALE,
    BE_EMIT
  } be_state_e;

  typedef enum logic [1:0] {
    AMB_MID,
    AMB_LOW,
    AMB_HIGH
  } amb_class_e;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] lux_sample;
    logic        night;
    logic        ota_exempt;
    logic [7:0]  colour_red;
    logic [7:0]  colour_green;
    logic [7:0]  colour_blue;
    logic [7:0]  level_top;
    logic [7:0]  level_middle;
    logic [7:0]  level_bottom;
  } frame_word_t;

  typedef struct packed {
    logic [3:0] pixel_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_pixel;
  } pixel_word_t;

  typedef struct packed {
    logic [7:0]  user_brightness;
    logic [15:0] window_low;
    logic [15:0] window_high;
    logic [8:0]  frame_interval_ms;
    logic [8:0]  dither_max_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0] colour_red;
    logic [7:0] colour_green;
    logic [7:0] colour_blue;
    logic [7:0] level_top;
    logic [7:0] level_middle;
    logic [7:0] level_bottom;
    logic [8:0] gamma;
    logic       dither_en;
  } frame_cmd_t;

  typedef logic [255:0][8:0] gamma_lut_t;

  // (floor(65535 * (m/255)^(11/5)) + 128) >> 8, exact integer search
  function automatic logic [8:0] gamma_entry(int unsigned m);
    logic [191:0] lhs;
    logic [191:0] rhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    rhs = 192'd1;
    for (int i = 0; i < 11; i++) rhs = rhs * 192'(m);
    for (int i = 0; i < 5; i++) rhs = rhs * 192'd65535;
    lo = 0;
    hi = 65535;
    for (int s = 0; s < 17; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 192'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * 192'(mid);
        for (int i = 0; i < 11; i++) lhs = lhs * 192'd255;
        if (lhs <= rhs) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return 9'((lo + 128) >> 8);
  endfunction

  function automatic gamma_lut_t build_gamma();
    gamma_lut_t lut;
    for (int m = 0; m < 256; m++) lut[m] = gamma_entry(m);
    return lut;
  endfunction

  localparam gamma_lut_t GAMMA_LUT = build_gamma();

endpackage

`default_nettype wire

/* sv/lfgd_div.sv */
// ----------------------------------------------------------------------------
// lfgd_div
// restoring divider, one quotient bit per cycle, quotient known to fit 8 bits
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfgd_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [lfgd_pkg::DIV_NUM_W-1:0]  dividend_i,
  input  wire logic [lfgd_pkg::DIV_DEN_W-1:0]  divisor_i,
  output logic                                 done_o,
  output logic [lfgd_pkg::DIV_Q_W-1:0]         quotient_o
);

  localparam int NumW = lfgd_pkg::DIV_NUM_W;
  localparam int DenW = lfgd_pkg::DIV_DEN_W;
  localparam int QW   = lfgd_pkg::DIV_Q_W;
  localparam int CntW = $clog2(QW);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [QW-1:0]   bits_q;
  logic [DenW:0]   trial;
  logic            ge;

  assign trial = {rem_q, bits_q[QW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend low bits shift out while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i[NumW-1:QW];
      bits_q <= dividend_i[QW-1:0];
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      bits_q <= {bits_q[QW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = bits_q;

  `LFGD_ASSERT(a_start_when_idle, start_i |-> !busy_q, "divider restarted while busy")
  `LFGD_ASSERT(a_quotient_fits, start_i |-> (dividend_i[NumW-1:QW] < divisor_i),
               "divider quotient would overflow")

endmodule

`default_nettype wire

/* sv/lfgd_front.sv */
// ----------------------------------------------------------------------------
// lfgd_front
// takes a frame, tracks the interval average, works out the gamma level and dither enable
// ----------------------------------------------------------------------------
`default_nettype none

module lfgd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lfgd_pkg::cfg_t        cfg_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lfgd_pkg::frame_word_t in_word_i,
  output logic                       push_o,
  output lfgd_pkg::frame_cmd_t       cmd_o,
  input  wire logic                  full_i
);

  lfgd_pkg::fe_state_e   state_q, state_d;
  lfgd_pkg::frame_word_t item_q, item_d;
  lfgd_pkg::amb_class_e  class_q, class_d;

  logic [31:0] prev_time_q, prev_time_d;
  logic [15:0] avg_q, avg_d;
  logic [8:0]  dt_q, dt_d;
  logic [15:0] diff_q, diff_d;
  logic [23:0] num_q, num_d;
  logic [7:0]  factor_q, factor_d;
  logic [15:0] prod_q, prod_d;
  logic        dither_q, dither_d;
  logic [8:0]  gamma_q, gamma_d;

  logic        div_start;
  logic        div_done;
  logic [7:0]  div_quot;
  logic [15:0] div_den;

  logic [31:0] delta;
  logic [31:0] dt_raw;
  logic [15:0] target;
  logic [7:0]  user_eff;
  logic [16:0] scaled;
  logic [7:0]  master;

  assign div_den = cfg_i.window_high - cfg_i.window_low;

  lfgd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfgd_pkg::FE_IDLE;
      prev_time_q <= '0;
      avg_q       <= lfgd_pkg::AVG_RESET;
    end else begin
      state_q     <= state_d;
      prev_time_q <= prev_time_d;
      avg_q       <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    class_q  <= class_d;
    dt_q     <= dt_d;
    diff_q   <= diff_d;
    num_q    <= num_d;
    factor_q <= factor_d;
    prod_q   <= prod_d;
    dither_q <= dither_d;
    gamma_q  <= gamma_d;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    class_d     = class_q;
    prev_time_d = prev_time_q;
    avg_d       = avg_q;
    dt_d        = dt_q;
    diff_d      = diff_q;
    num_d       = num_q;
    factor_d    = factor_q;
    prod_d      = prod_q;
    dither_d    = dither_q;
    gamma_d     = gamma_q;
    in_ready_o  = 1'b0;
    push_o      = 1'b0;
    div_start   = 1'b0;

    delta    = item_q.time_ms - prev_time_q;
    dt_raw   = (prev_time_q == '0) ? 32'(cfg_i.frame_interval_ms) : delta;
    target   = {3'b000, dt_q, 4'b0000};
    user_eff = (cfg_i.user_brightness == '0) ? 8'd1 : cfg_i.user_brightness;
    // x / 255 for any x up to 65534, which covers every byte product
    scaled   = (17'(prod_q) + 17'(prod_q[15:8]) + 17'd1) >> 8;
    master   = scaled[7:0];
    if (item_q.night && !item_q.ota_exempt && master > lfgd_pkg::DARK_LIMIT) begin
      master = lfgd_pkg::DARK_LIMIT;
    end

    unique case (state_q)
      lfgd_pkg::FE_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_word_i;
          state_d = lfgd_pkg::FE_INTERVAL;
        end
      end
      lfgd_pkg::FE_INTERVAL: begin
        dt_d        = (dt_raw > 32'(lfgd_pkg::DT_MAX)) ? lfgd_pkg::DT_MAX : dt_raw[8:0];
        prev_time_d = (item_q.time_ms == '0) ? 32'd1 : item_q.time_ms;
        diff_d      = item_q.lux_sample - cfg_i.window_low;
        if (item_q.lux_sample >= cfg_i.window_high) begin
          class_d = lfgd_pkg::AMB_HIGH;
        end else if (item_q.lux_sample <= cfg_i.window_low) begin
          class_d = lfgd_pkg::AMB_LOW;
        end else begin
          class_d = lfgd_pkg::AMB_MID;
        end
        state_d = lfgd_pkg::FE_AVERAGE;
      end
      lfgd_pkg::FE_AVERAGE: begin
        if (target >= avg_q) begin
          avg_d = avg_q + ((target - avg_q) >> 2);
        end else begin
          avg_d = avg_q - ((avg_q - target) >> 2);
        end
        num_d   = 24'(diff_q) * 24'(lfgd_pkg::FACTOR_SPAN);
        state_d = lfgd_pkg::FE_RANGE;
      end
      lfgd_pkg::FE_RANGE: begin
        dither_d = avg_q[15:4] <= 12'(cfg_i.dither_max_interval_ms);
        case (class_q)
          lfgd_pkg::AMB_HIGH: begin
            factor_d = lfgd_pkg::FACTOR_MAX;
            state_d  = lfgd_pkg::FE_SCALE;
          end
          lfgd_pkg::AMB_LOW: begin
            factor_d = lfgd_pkg::FACTOR_MIN;
            state_d  = lfgd_pkg::FE_SCALE;
          end
          default: begin
            div_start = 1'b1;
            state_d   = lfgd_pkg::FE_DIVIDE;
          end
        endcase
      end
      lfgd_pkg::FE_DIVIDE: begin
        if (div_done) begin
          factor_d = lfgd_pkg::FACTOR_MIN + div_quot;
          state_d  = lfgd_pkg::FE_SCALE;
        end
      end
      lfgd_pkg::FE_SCALE: begin
        prod_d  = 16'(user_eff) * 16'(factor_q);
        state_d = lfgd_pkg::FE_GAMMA;
      end
      lfgd_pkg::FE_GAMMA: begin
        gamma_d = lfgd_pkg::GAMMA_LUT[master];
        state_d = lfgd_pkg::FE_PUSH;
      end
      lfgd_pkg::FE_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = lfgd_pkg::FE_IDLE;
        end
      end
      default: begin
        state_d = lfgd_pkg::FE_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.colour_red   = item_q.colour_red;
    cmd_o.colour_green = item_q.colour_green;
    cmd_o.colour_blue  = item_q.colour_blue;
    cmd_o.level_top    = item_q.level_top;
    cmd_o.level_middle = item_q.level_middle;
    cmd_o.level_bottom = item_q.level_bottom;
    cmd_o.gamma        = gamma_q;
    cmd_o.dither_en    = dither_q;
  end

endmodule

`default_nettype wire

/* sv/lfgd_fifo.sv */
// ----------------------------------------------------------------------------
// lfgd_fifo
// short register queue carrying frame commands from front to back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfgd_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire lfgd_pkg::frame_cmd_t data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output lfgd_pkg::frame_cmd_t      data_o,
  output logic                      empty_o
);

  localparam int Depth = lfgd_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lfgd_pkg::frame_cmd_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `LFGD_ASSERT(a_no_overflow, push_i |-> !full_o, "frame queue overflow")
  `LFGD_ASSERT(a_no_underflow, pop_i |-> !empty_o, "frame queue underflow")

endmodule

`default_nettype wire

/* sv/lfgd_back.sv */
// ----------------------------------------------------------------------------
// lfgd_back
// per-pixel scaling, dither or rounding, and the output word register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lfgd_back #(
  parameter int PixelCount  = lfgd_pkg::PIXEL_COUNT,
  parameter int FittedCount = lfgd_pkg::FITTED_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  input  wire lfgd_pkg::frame_cmd_t cmd_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lfgd_pkg::pixel_word_t     out_word_o
);

  localparam int IdxW = $clog2(PixelCount);

  lfgd_pkg::be_state_e   state_q, state_d;
  lfgd_pkg::frame_cmd_t  cmd_q, cmd_d;
  lfgd_pkg::pixel_word_t out_q, out_d;

  logic [3:0]  pix_q, pix_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0][15:0] p1_q, p1_d;
  logic [2:0][23:0] p2_q, p2_d;
  logic [2:0][15:0] c16_q, c16_d;
  logic [2:0][7:0]  res_q [PixelCount];
  logic [2:0][7:0]  res_new;
  logic [2:0][7:0]  bytes;
  logic [2:0][7:0]  col;
  logic [7:0]       lvl [lfgd_pkg::LEVEL_COUNT];
  logic [7:0]       level;
  logic [IdxW-1:0]  idx;
  logic             last;
  logic             load;
  logic [63:0]      recip_prod [3];
  logic [15:0]      sum [3];

  assign idx  = pix_q[IdxW-1:0];
  assign last = pix_q == 4'(PixelCount - 1);
  assign load = (state_q == lfgd_pkg::BE_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    col[0] = cmd_q.colour_red;
    col[1] = cmd_q.colour_green;
    col[2] = cmd_q.colour_blue;
    lvl[0] = cmd_q.level_top;
    lvl[1] = cmd_q.level_middle;
    lvl[2] = cmd_q.level_bottom;
    level  = (pix_q < 4'(FittedCount)) ? lvl[pix_q[1:0]] : 8'd0;
    for (int k = 0; k < 3; k++) begin
      recip_prod[k] = 64'(p2_q[k]) * 64'(lfgd_pkg::RECIP_255);
      if (cmd_q.dither_en) begin
        sum[k]     = c16_q[k] + 16'(res_q[idx][k]);
        res_new[k] = sum[k][7:0];
      end else begin
        sum[k]     = c16_q[k] + lfgd_pkg::ROUND_HALF;
        res_new[k] = 8'd0;
      end
      bytes[k] = sum[k][15:8];
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    pix_d       = pix_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    p1_d        = p1_q;
    p2_d        = p2_q;
    c16_d       = c16_q;
    pop_o       = 1'b0;

    unique case (state_q)
      lfgd_pkg::BE_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          pix_d   = '0;
          state_d = lfgd_pkg::BE_MUL1;
        end
      end
      lfgd_pkg::BE_MUL1: begin
        for (int k = 0; k < 3; k++) p1_d[k] = 16'(col[k]) * 16'(level);
        state_d = lfgd_pkg::BE_MUL2;
      end
      lfgd_pkg::BE_MUL2: begin
        for (int k = 0; k < 3; k++) p2_d[k] = 24'(p1_q[k]) * 24'(cmd_q.gamma);
        state_d = lfgd_pkg::BE_SCALE;
      end
      lfgd_pkg::BE_SCALE: begin
        for (int k = 0; k < 3; k++) c16_d[k] = recip_prod[k][47:32];
        state_d = lfgd_pkg::BE_EMIT;
      end
      lfgd_pkg::BE_EMIT: begin
        if (load) begin
          out_valid_d       = 1'b1;
          out_d.pixel_index = pix_q;
          out_d.out_red     = bytes[0];
          out_d.out_green   = bytes[1];
          out_d.out_blue    = bytes[2];
          out_d.last_pixel  = last;
          if (last) begin
            state_d = lfgd_pkg::BE_IDLE;
          end else begin
            pix_d   = pix_q + 1'b1;
            state_d = lfgd_pkg::BE_MUL1;
          end
        end
      end
      default: begin
        state_d = lfgd_pkg::BE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lfgd_pkg::BE_IDLE;
      out_valid_q <= 1'b0;
      pix_q       <= '0;
      for (int i = 0; i < PixelCount; i++) res_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pix_q       <= pix_d;
      if (load) begin
        res_q[idx] <= res_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
    p1_q  <= p1_d;
    p2_q  <= p2_d;
    c16_q <= c16_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `LFGD_ASSERT(a_residue_cleared, (load && !cmd_q.dither_en) |=> (res_q[$past(idx)] == '0),
               "residue not cleared while dither off")
  `LFGD_ASSERT(a_pixel_in_range, (state_q != lfgd_pkg::BE_IDLE) |-> (pix_q <= 4'(PixelCount - 1)),
               "pixel counter past end of chain")

endmodule

`default_nettype wire

/* sv/led_frame_gamma_dither.sv */
// ----------------------------------------------------------------------------
// led_frame_gamma_dither
// ambient-scaled, night-limited, gamma-corrected led column renderer with
// temporal dither
// ----------------------------------------------------------------------------
// one frame word enters on in_valid_i/in_ready_o; PixelCount pixel words
// leave on out_valid_o/out_ready_i, pixel 0 first, last_pixel set on the final
// one. registers sit on an apb port at 4*index; the user makes writes
// only while idle, which the block itself does not enforce. the front takes
// a new frame only once it has pushed the last; inside the window it waits
// on the 8-step divider, outside it does not divide. the back fetches a frame
// and then runs MUL1, MUL2, SCALE and EMIT for each pixel; a two-entry queue
// sits between the two. after reset the interval average holds 256, no frame
// has been seen and all dither residues are zero; the block accepts at once.
// a stalled receiver holds the output register, the back then waits and the
// queue fills, after which the front stops taking frames.
// ----------------------------------------------------------------------------
`default_nettype none

module led_frame_gamma_dither #(
  parameter int PixelCount  = lfgd_pkg::PIXEL_COUNT,
  parameter int FittedCount = lfgd_pkg::FITTED_COUNT
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire lfgd_pkg::frame_word_t                 in_word_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output lfgd_pkg::pixel_word_t                      out_word_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [lfgd_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [lfgd_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [lfgd_pkg::APB_DATA_W-1:0]            prdata,
  output logic                                       pready
);

  lfgd_pkg::cfg_t       cfg_q;
  lfgd_pkg::cfg_reg_e   reg_sel;
  lfgd_pkg::frame_cmd_t push_cmd;
  lfgd_pkg::frame_cmd_t pop_cmd;

  logic wr_en;
  logic push;
  logic pop;
  logic full;
  logic empty;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = lfgd_pkg::cfg_reg_e'(paddr[lfgd_pkg::APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.user_brightness        <= lfgd_pkg::USER_RESET;
      cfg_q.window_low             <= lfgd_pkg::WIN_LOW_RESET;
      cfg_q.window_high            <= lfgd_pkg::WIN_HIGH_RESET;
      cfg_q.frame_interval_ms      <= lfgd_pkg::FRAME_IV_RESET;
      cfg_q.dither_max_interval_ms <= lfgd_pkg::DITHER_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        lfgd_pkg::REG_USER_BRIGHTNESS: cfg_q.user_brightness        <= pwdata[7:0];
        lfgd_pkg::REG_WINDOW_LOW:      cfg_q.window_low             <= pwdata[15:0];
        lfgd_pkg::REG_WINDOW_HIGH:     cfg_q.window_high            <= pwdata[15:0];
        lfgd_pkg::REG_FRAME_INTERVAL:  cfg_q.frame_interval_ms      <= pwdata[8:0];
        lfgd_pkg::REG_DITHER_MAX:      cfg_q.dither_max_interval_ms <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lfgd_pkg::REG_USER_BRIGHTNESS: prdata = 32'(cfg_q.user_brightness);
      lfgd_pkg::REG_WINDOW_LOW:      prdata = 32'(cfg_q.window_low);
      lfgd_pkg::REG_WINDOW_HIGH:     prdata = 32'(cfg_q.window_high);
      lfgd_pkg::REG_FRAME_INTERVAL:  prdata = 32'(cfg_q.frame_interval_ms);
      lfgd_pkg::REG_DITHER_MAX:      prdata = 32'(cfg_q.dither_max_interval_ms);
      default:                       prdata = '0;
    endcase
  end

  lfgd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  lfgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  lfgd_back #(
    .PixelCount  (PixelCount),
    .FittedCount (FittedCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
